/* rtl/bpff_pkg.sv */
// bpff_pkg: shared types and constants of the bin packing engine
// request/result payload structs, register codes, controller command and status
// no dependencies
`timescale 1ns / 1ps

package bpff_pkg;

   localparam int ID_W          = 16;
   localparam int WEIGHT_W      = 16;
   localparam int BIN_IDX_W     = 6;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 16;

   localparam int MAX_BINS_DEFAULT    = 64;
   localparam int WEIGHT_BITS_DEFAULT = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_CAPACITY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_STRATEGY = 1'b1;

   localparam logic [CSR_DATA_W-1:0] BIN_CAPACITY_RESET = 16'hFFFF;

   // fit strategy codes
   localparam logic STRATEGY_FIRST_FIT = 1'b0;
   localparam logic STRATEGY_BEST_FIT  = 1'b1;

   typedef struct packed {
      logic                start_new;
      logic [ID_W-1:0]     object_id;
      logic [WEIGHT_W-1:0] item_weight;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]      placed_id;
      logic [BIN_IDX_W-1:0] bin_index;
      logic                 opened_new;
      logic                 oversize;
      logic                 no_free_bin;
   } rsp_type;

   typedef struct packed {
      logic load;    // latch request, reset scan
      logic issue;   // read next bin, advance scan address
      logic commit;  // write back chosen bin, register result
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } ctrl_sts_type;

endpackage

/* rtl/bpff_ctrl.sv */
// bpff_ctrl: controller state machine of the bin packing engine
// sequences load, scan and commit; depends on bpff_pkg
`timescale 1ns / 1ps

module bpff_ctrl
   import bpff_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_SCAN;
                  busy_ff  <= 1'b1;
               end
            end
            S_SCAN: begin
               if (sts.scan_done) begin
                  state_ff <= S_COMMIT;
               end
            end
            S_COMMIT: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd.load   = (state_ff == S_IDLE) && start;
      cmd.issue  = (state_ff == S_SCAN) && !sts.scan_done;
      cmd.commit = (state_ff == S_COMMIT);
   end

   assign busy = busy_ff;

`ifndef NO_ASSERTIONS
   a_busy_matches_state: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != S_IDLE))
      else $error("busy out of step with controller state");

   a_commit_follows_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $past(state_ff == S_SCAN) && $past(sts.scan_done))
      else $error("commit without a finished scan");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_SCAN))
      else $error("load did not start a scan");
`endif

endmodule

/* rtl/bpff_dpath.sv */
// bpff_dpath: datapath of the bin packing engine
// space memory, scan pipeline, fit selection, write-back and result register
// depends on bpff_pkg; driven by bpff_ctrl commands
`timescale 1ns / 1ps

module bpff_dpath
   import bpff_pkg::*;
#(
   parameter int MAX_BINS    = MAX_BINS_DEFAULT,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  ctrl_cmd_type          cmd,
   output ctrl_sts_type          sts,
   output logic                  rsp_strobe,
   output rsp_type               rsp_item
);

   localparam int AW = $clog2(MAX_BINS);
   localparam int CW = $clog2(MAX_BINS + 1);
   localparam logic [CW-1:0] BINS_LIMIT = CW'(MAX_BINS);

   // configuration
   logic [CSR_DATA_W-1:0]  cap_ff;
   logic                   strategy_ff;

   // latched request
   logic [ID_W-1:0]        id_ff;
   logic [WEIGHT_BITS-1:0] w_ff;

   // scan state
   logic [CW-1:0]          bins_open_ff;
   logic [CW-1:0]          scan_addr_ff;
   logic                   rd_vld_ff;
   logic [AW-1:0]          rd_idx_ff;
   logic [WEIGHT_BITS-1:0] rd_data_ff;
   logic                   found_ff;
   logic [AW-1:0]          pick_ff;
   logic [WEIGHT_BITS-1:0] best_ff;

   // result
   logic                   rsp_strobe_ff;
   rsp_type                rsp_item_ff;

   logic [WEIGHT_BITS-1:0] mem [MAX_BINS];

   logic [WEIGHT_BITS-1:0] cap_w;
   logic                   fits;
   logic                   take;
   logic                   can_open;
   logic                   over;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [WEIGHT_BITS-1:0] wr_data;

   assign cap_w    = WEIGHT_BITS'(cap_ff);
   assign fits     = rd_vld_ff && (rd_data_ff >= w_ff);
   assign take     = fits && (!found_ff ||
                     ((strategy_ff == STRATEGY_BEST_FIT) && (rd_data_ff < best_ff)));
   assign can_open = bins_open_ff < BINS_LIMIT;
   assign over     = w_ff > cap_w;

   assign sts.scan_done = (scan_addr_ff == bins_open_ff);

   // write-back: shrink the chosen bin or open the next one
   always_comb begin
      wr_en   = cmd.commit && (found_ff || can_open);
      wr_addr = found_ff ? pick_ff : bins_open_ff[AW-1:0];
      if (found_ff) begin
         wr_data = best_ff - w_ff;
      end else if (over) begin
         wr_data = '0;
      end else begin
         wr_data = cap_w - w_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[scan_addr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= BIN_CAPACITY_RESET;
         strategy_ff <= STRATEGY_FIRST_FIT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BIN_CAPACITY: cap_ff      <= csr_wdata;
            CSR_FIT_STRATEGY: strategy_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bins_open_ff  <= '0;
         scan_addr_ff  <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rd_vld_ff     <= cmd.issue;
         rsp_strobe_ff <= cmd.commit;
         if (cmd.load) begin
            scan_addr_ff <= '0;
            found_ff     <= 1'b0;
            if (req_item.start_new) begin
               bins_open_ff <= '0;
            end
         end else begin
            if (cmd.issue) begin
               scan_addr_ff <= scan_addr_ff + 1'b1;
            end
            if (take) begin
               found_ff <= 1'b1;
            end
            if (cmd.commit && !found_ff && can_open) begin
               bins_open_ff <= bins_open_ff + 1'b1;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff <= req_item.object_id;
         w_ff  <= WEIGHT_BITS'(req_item.item_weight);
      end
      if (cmd.issue) begin
         rd_idx_ff <= scan_addr_ff[AW-1:0];
      end
      if (!cmd.load && take) begin
         pick_ff <= rd_idx_ff;
         best_ff <= rd_data_ff;
      end
      if (cmd.commit) begin
         rsp_item_ff.placed_id <= id_ff;
         if (found_ff) begin
            rsp_item_ff.bin_index   <= BIN_IDX_W'(pick_ff);
            rsp_item_ff.opened_new  <= 1'b0;
            rsp_item_ff.oversize    <= 1'b0;
            rsp_item_ff.no_free_bin <= 1'b0;
         end else if (can_open) begin
            rsp_item_ff.bin_index   <= BIN_IDX_W'(bins_open_ff);
            rsp_item_ff.opened_new  <= 1'b1;
            rsp_item_ff.oversize    <= over;
            rsp_item_ff.no_free_bin <= 1'b0;
         end else begin
            rsp_item_ff.bin_index   <= '0;
            rsp_item_ff.opened_new  <= 1'b0;
            rsp_item_ff.oversize    <= 1'b0;
            rsp_item_ff.no_free_bin <= 1'b1;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

`ifndef NO_ASSERTIONS
   a_bins_bounded: assert property (@(posedge clock) disable iff (reset)
      bins_open_ff <= BINS_LIMIT)
      else $error("open bin count above limit");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (scan_addr_ff < bins_open_ff))
      else $error("scan read beyond open bins");

   a_strobe_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(cmd.commit))
      else $error("result strobe without commit");

   a_open_counts_up: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_item_ff.opened_new) |->
         (bins_open_ff == CW'($past(bins_open_ff) + 1'b1)))
      else $error("opened bin not counted");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !(rsp_item_ff.opened_new && rsp_item_ff.no_free_bin))
      else $error("opened and no free bin together");
`endif

endmodule

/* rtl/bin_packing_first_best_fit.sv */
// bin_packing_first_best_fit: top level of the online bin packing engine
// joins controller bpff_ctrl and datapath bpff_dpath; depends on bpff_pkg
//
// channel   ports                             handshake
// request   start, busy, req_item             taken when start high and busy low
// result    rsp_strobe, rsp_item              one cycle per result, cannot be held off
// config    csr_we, csr_index, csr_wdata      written when csr_we high, no wait
//
// the time from one acceptance to the next is set by the scan of the open bins
// (at most MAX_BINS) in the space memory, one bin per cycle through its single read
// port, then by one write-back
// the result strobe follows the write-back; a new request may be taken in that cycle
// reset is synchronous and active high: no open bins, capacity 65535, first fit
// the space memory needs no clearing pass: only bins already opened are read
`timescale 1ns / 1ps

module bin_packing_first_best_fit
   import bpff_pkg::*;
#(
   parameter int MAX_BINS    = MAX_BINS_DEFAULT,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_item,
   // result channel
   output logic                  rsp_strobe,
   output rsp_type               rsp_item,
   // configuration port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // command and status between controller and datapath
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // controller: idle, scan of open bins, commit
   bpff_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // datapath: space memory, fit selection, bin count, result register
   bpff_dpath #(
      .MAX_BINS    (MAX_BINS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
